// File: hw/rtl/afm_pkg.sv
// Shared widths, coefficients and control types of the ACES fitted tone map.
`default_nettype none
package afm_pkg;

	// Fixed-point format of the pixel samples.
	localparam int FRACTION_BITS = 12;
	localparam int PIX_W         = 16;
	localparam int COEF_W        = 18;

	// Matrix output, Q16 with the integer range that the input format allows.
	localparam int M_W   = 32 - FRACTION_BITS;
	localparam int IP_W  = COEF_W + PIX_W;
	localparam int IA_W  = IP_W + 2;

	// Curve datapath widths.
	localparam int CT_W  = COEF_W + M_W;
	localparam int CV_W  = (M_W + 2 > 17) ? M_W + 2 : 17;
	localparam int PM_W  = M_W + CV_W;
	localparam int ND_W  = ((PM_W > 32) ? PM_W : 32) + 1;
	localparam int DEN_W = ND_W - 1;
	localparam int NQ_W  = ND_W + 17;

	// Divider: the curve stays well inside [-2^KB, 2^QB - 2^KB) in Q16, so the
	// dividend is offset by 2^KB divisors and an unsigned divide of QB bits is enough.
	localparam int QB    = 17;
	localparam int KB    = 8;
	localparam int K_OFF = 1 << KB;
	localparam int Q_W   = QB + 1;

	// Output matrix widths.
	localparam int OP_W    = COEF_W + Q_W;
	localparam int OA_W    = OP_W + 2;
	localparam int OSH     = 32 - FRACTION_BITS;
	localparam int TOP_VAL = (FRACTION_BITS >= 15) ? 32767 : (1 << FRACTION_BITS);
	localparam int BOT_VAL = -32768;

	// Pipeline depths.
	localparam int IM_ST   = 2;
	localparam int LANE_ST = 5 + QB + 1;
	localparam int MG_ST   = 2;
	localparam int PIPE_ST = IM_ST + LANE_ST + MG_ST;

	typedef logic signed [PIX_W-1:0]  pix_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [M_W-1:0]    m_t;
	typedef logic signed [Q_W-1:0]    q_t;

	// Input matrix, Q16.
	localparam coef_t CIN [3][3] = '{
		'{18'sd39137, 18'sd23238, 18'sd3161},
		'{18'sd4981,  18'sd59529, 18'sd1026},
		'{18'sd1861,  18'sd8771,  18'sd54904}
	};

	// Output matrix, Q16.
	localparam coef_t COUT [3][3] = '{
		'{18'sd105169, -18'sd34805, -18'sd4828},
		'{-18'sd6690,  18'sd72622,  -18'sd396},
		'{-18'sd214,   -18'sd4768,  18'sd70518}
	};

	// Rational curve constants, Q16.
	localparam coef_t CURVE_A = 18'sd1611;
	localparam coef_t CURVE_B = 18'sd6;
	localparam coef_t CURVE_C = 18'sd64470;
	localparam coef_t CURVE_D = 18'sd28374;
	localparam coef_t CURVE_E = 18'sd15602;

	// Per-stage load enables and valid flags handed to a curve lane.
	typedef struct packed {
		logic [LANE_ST-1:0] en;
		logic [LANE_ST-1:0] vld;
	} lane_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/afm_lane.sv
// Curve lane: the fitted rational curve on one channel, with a pipelined divider.
`default_nettype none
module afm_lane (
	input  logic               clk,
	input  afm_pkg::lane_ctl_t ctl,
	input  afm_pkg::m_t        m,
	output afm_pkg::q_t        q
);
	import afm_pkg::*;

	localparam int DIV_EN0 = 5;

	m_t                     m_s1;
	m_t                     m_s2;
	logic signed [CT_W-1:0] ct_s1;
	logic signed [CT_W-1:0] t_w;
	logic signed [CV_W-1:0] ma_s2;
	logic signed [CV_W-1:0] td_s2;
	logic signed [PM_W-1:0] pmm_s3;
	logic signed [PM_W-1:0] pmt_s3;
	logic signed [ND_W-1:0] num_w;
	logic signed [ND_W-1:0] den_w;
	logic signed [ND_W-1:0] num_s4;
	logic signed [ND_W-1:0] den_s4;
	logic signed [NQ_W-1:0] nq_w;
	// Element j of the divider arrays belongs to stage 5 + j.
	logic [DEN_W-1:0]       rem_s5 [QB+1];
	logic [DEN_W-1:0]       den_s5 [QB+1];
	logic [QB-1:0]          lq_s5  [QB+1];
	q_t                     q_s23;

	assign t_w   = (ct_s1 + CT_W'(1 << 15)) >>> 16;
	assign num_w = ND_W'(pmm_s3) - (ND_W'(CURVE_B) <<< 16);
	assign den_w = ND_W'(pmt_s3) + (ND_W'(CURVE_E) <<< 16);
	// Dividend with half a divisor for rounding and the offset that keeps it positive.
	assign nq_w  = (NQ_W'(num_s4) <<< 16) + NQ_W'(den_s4 >>> 1) + (NQ_W'(den_s4) <<< KB);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			ct_s1 <= CT_W'(CURVE_C) * CT_W'(m);
			m_s1  <= m;
		end
		if (ctl.en[1]) begin
			ma_s2 <= CV_W'(m_s1) + CV_W'(CURVE_A);
			td_s2 <= CV_W'(t_w) + CV_W'(CURVE_D);
			m_s2  <= m_s1;
		end
		if (ctl.en[2]) begin
			pmm_s3 <= PM_W'(m_s2) * PM_W'(ma_s2);
			pmt_s3 <= PM_W'(m_s2) * PM_W'(td_s2);
		end
		if (ctl.en[3]) begin
			num_s4 <= num_w;
			den_s4 <= (den_w < ND_W'(1)) ? ND_W'(1) : den_w;
		end
		if (ctl.en[4]) begin
			rem_s5[0] <= nq_w[NQ_W-2:QB];
			lq_s5[0]  <= nq_w[QB-1:0];
			den_s5[0] <= den_s4[DEN_W-1:0];
		end
		if (ctl.en[LANE_ST-1]) begin
			q_s23 <= $signed({1'b0, lq_s5[QB]}) - Q_W'(K_OFF);
		end
	end

	// One restoring step per stage: dividend bits shift out of lq at the top
	// while quotient bits shift in at the bottom.
	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [DEN_W:0]   sh;
		logic [DEN_W+1:0] diff;

		assign sh   = {rem_s5[j], lq_s5[j][QB-1]};
		assign diff = {1'b0, sh} - {2'b00, den_s5[j]};

		always_ff @(posedge clk) begin
			if (ctl.en[DIV_EN0+j]) begin
				rem_s5[j+1] <= diff[DEN_W+1] ? sh[DEN_W-1:0] : diff[DEN_W-1:0];
				lq_s5[j+1]  <= {lq_s5[j][QB-2:0], ~diff[DEN_W+1]};
				den_s5[j+1] <= den_s5[j];
			end
		end
	end

	assign q = q_s23;

`ifndef ASSERT_OFF
	a_den_positive: assert property (@(posedge clk)
		ctl.vld[2] |-> (den_w > ND_W'(0)))
		else $error("curve denominator not positive");
	a_dividend_positive: assert property (@(posedge clk)
		ctl.vld[3] |-> !nq_w[NQ_W-1])
		else $error("offset dividend is negative");
	a_quotient_fits: assert property (@(posedge clk)
		ctl.vld[4] |-> (rem_s5[0] < den_s5[0]))
		else $error("quotient exceeds divider width");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/afm_merge.sv
// Merge stage: output matrix over the three lanes, rounding and clamping.
`default_nettype none
module afm_merge (
	input  logic               clk,
	input  logic [1:0]         en,
	input  afm_pkg::q_t        q [3],
	output afm_pkg::pix_t      y [3]
);
	import afm_pkg::*;

	logic signed [OP_W-1:0] prod_s1 [3][3];
	logic signed [OA_W-1:0] acc_w   [3];
	logic signed [OA_W-1:0] shr_w   [3];
	pix_t                   y_s2    [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_w[i] = OA_W'(prod_s1[i][0]) + OA_W'(prod_s1[i][1]) + OA_W'(prod_s1[i][2])
				+ (OA_W'(1) <<< (OSH - 1));
			shr_w[i] = acc_w[i] >>> OSH;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (en[0]) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= OP_W'(COUT[i][j]) * OP_W'(q[j]);
				end
			end
			if (en[1]) begin
				if (shr_w[i] > OA_W'(TOP_VAL)) begin
					y_s2[i] <= PIX_W'(TOP_VAL);
				end else if (shr_w[i] < OA_W'(BOT_VAL)) begin
					y_s2[i] <= PIX_W'(BOT_VAL);
				end else begin
					y_s2[i] <= PIX_W'(shr_w[i]);
				end
			end
		end
	end

	assign y = y_s2;

endmodule
`default_nettype wire

// File: hw/rtl/aces_fitted_tone_map_top.sv
// Top level of the ACES fitted tone map: input matrix, three curve lanes, output merge.
//
//   Channel  Beat contents                               Handshake
//   src      red_in, green_in, blue_in, last_in_row      src_valid / src_stall
//   dst      red_out, green_out, blue_out, row_end       dst_valid / dst_stall
//
// One pixel beat is taken per clock cycle while src_stall is low; each pixel passes
// through the input matrix, a curve lane with its one-bit-per-stage divider, and
// the output matrix and clamp.
// Reset clears only the stage valid flags; there is nothing else to initialize.
// A stalled output holds only the full stages at the end of the pipe: empty stages further up still fill,
// so src_stall rises only once every stage holds a pixel and dst_stall is high.
`default_nettype none
module aces_fitted_tone_map_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_stall,
	input  afm_pkg::pix_t red_in,
	input  afm_pkg::pix_t green_in,
	input  afm_pkg::pix_t blue_in,
	input  logic          last_in_row,
	output logic          dst_valid,
	input  logic          dst_stall,
	output afm_pkg::pix_t red_out,
	output afm_pkg::pix_t green_out,
	output afm_pkg::pix_t blue_out,
	output logic          row_end
);
	import afm_pkg::*;

	// Stage k of the pipeline holds a pixel when v_q[k] is set. A stage loads
	// when it is empty or when the stage after it moves on.
	logic [PIPE_ST-1:0] v_q;
	logic [PIPE_ST-1:0] v_nxt;
	logic [PIPE_ST-1:0] go;
	// Bit k of the row flag travels with stage k.
	logic [PIPE_ST-1:0] last_s1;
	logic [PIPE_ST-1:0] last_nxt;

	pix_t                   pix_w   [3];
	logic signed [IP_W-1:0] prod_s1 [3][3];
	logic signed [IA_W-1:0] sum_w   [3];
	m_t                     m_s2    [3];
	q_t                     q_w     [3];
	pix_t                   y_w     [3];
	lane_ctl_t              lane_ctl;

	// A stage can load unless it and every stage below it are full and the
	// output is held.
	for (genvar k = 0; k < PIPE_ST; k++) begin : g_go
		assign go[k] = !dst_stall || !(&v_q[PIPE_ST-1:k]);
	end

	assign src_stall = !go[0];
	assign v_nxt     = {v_q[PIPE_ST-2:0], src_valid};
	assign last_nxt  = {last_s1[PIPE_ST-2:0], last_in_row};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < PIPE_ST; k++) begin
				if (go[k]) begin
					v_q[k] <= v_nxt[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < PIPE_ST; k++) begin
			if (go[k]) begin
				last_s1[k] <= last_nxt[k];
			end
		end
	end

	// Input matrix: nine constant products, then the row sums rounded to Q16.
	assign pix_w[0] = red_in;
	assign pix_w[1] = green_in;
	assign pix_w[2] = blue_in;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_w[i] = IA_W'(prod_s1[i][0]) + IA_W'(prod_s1[i][1]) + IA_W'(prod_s1[i][2])
				+ (IA_W'(1) <<< (FRACTION_BITS - 1));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (go[0]) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= IP_W'(CIN[i][j]) * IP_W'(pix_w[j]);
				end
			end
			if (go[1]) begin
				m_s2[i] <= M_W'(sum_w[i] >>> FRACTION_BITS);
			end
		end
	end

	// The three channels run through identical curve lanes in lockstep.
	assign lane_ctl.en  = go[IM_ST +: LANE_ST];
	assign lane_ctl.vld = v_q[IM_ST +: LANE_ST];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		afm_lane u_lane (
			.clk (clk),
			.ctl (lane_ctl),
			.m   (m_s2[i]),
			.q   (q_w[i])
		);
	end

	// The merge combines the lane results through the output matrix; its
	// last stage is the output register.
	afm_merge u_merge (
		.clk (clk),
		.en  (go[IM_ST+LANE_ST +: MG_ST]),
		.q   (q_w),
		.y   (y_w)
	);

	assign dst_valid = v_q[PIPE_ST-1];
	assign red_out   = y_w[0];
	assign green_out = y_w[1];
	assign blue_out  = y_w[2];
	assign row_end   = last_s1[PIPE_ST-1];

`ifndef ASSERT_OFF
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> ((&v_q) && dst_stall))
		else $error("input held while the pipeline has room");
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(dst_valid) |-> $past(!v_q[PIPE_ST-2] && !dst_stall))
		else $error("output beat lost or not refilled");
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		arst_n |=> ($countones(v_q) == $past($countones(v_q))
			+ int'($past(src_valid && !src_stall))
			- int'($past(dst_valid && !dst_stall))))
		else $error("pixel count in flight does not balance");
`endif

endmodule
`default_nettype wire

// File: test/aces_fitted_tone_map_top_test.sv
// Self-checking testbench for the ACES fitted tone map top level.
`timescale 1ns / 100ps

module aces_fitted_tone_map_top_test;
	import afm_pkg::pix_t;

	// The sample format comes from the package; the coefficient constants below
	// are independent copies of the Q16 values, so that a wrong coefficient
	// in the design shows up as a mismatch.
	localparam int FB        = afm_pkg::FRACTION_BITS;
	localparam int OUT_SHIFT = 32 - FB;

	localparam longint IN_RR = 39137;
	localparam longint IN_RG = 23238;
	localparam longint IN_RB = 3161;
	localparam longint IN_GR = 4981;
	localparam longint IN_GG = 59529;
	localparam longint IN_GB = 1026;
	localparam longint IN_BR = 1861;
	localparam longint IN_BG = 8771;
	localparam longint IN_BB = 54904;

	localparam longint OUT_RR = 105169;
	localparam longint OUT_RG = -34805;
	localparam longint OUT_RB = -4828;
	localparam longint OUT_GR = -6690;
	localparam longint OUT_GG = 72622;
	localparam longint OUT_GB = -396;
	localparam longint OUT_BR = -214;
	localparam longint OUT_BG = -4768;
	localparam longint OUT_BB = 70518;

	localparam longint CRV_A = 1611;
	localparam longint CRV_B = 6;
	localparam longint CRV_C = 64470;
	localparam longint CRV_D = 28374;
	localparam longint CRV_E = 15602;

	localparam pix_t PIX_MAX = 32767;
	localparam pix_t PIX_MIN = -32768;
	localparam pix_t PIX_ONE = 1 << FB;

	// Cycles with no beat on either channel before the run is declared hung.
	// A correct run never stays quiet much longer than the pipeline takes to
	// drain plus its random idling, so this leaves a wide margin.
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PRINT_LIMIT  = 30;

	// Value ranges that the random pixels are drawn from.
	typedef enum int {
		SPAN_FULL,   // any 16-bit pattern, negatives included
		SPAN_HDR,    // non-negative, up to just under 8.0
		SPAN_KNEE,   // around black, on both sides of zero
		SPAN_SDR     // 0.0 to 2.0
	} sample_span_e;

	typedef struct {
		pix_t red;
		pix_t green;
		pix_t blue;
		logic last;
	} rgb_pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic src_valid = 1'b0;
	logic src_stall;
	pix_t red_in = '0;
	pix_t green_in = '0;
	pix_t blue_in = '0;
	logic last_in_row = 1'b0;

	logic dst_valid;
	logic dst_stall = 1'b0;
	pix_t red_out;
	pix_t green_out;
	pix_t blue_out;
	logic row_end;

	// Tone-mapped pixels still owed by the block, oldest first.
	rgb_pixel_t pending_pixels [$];

	int src_idle_pct = 38;
	int dst_idle_pct = 38;

	int mismatches = 0;
	int pixels_sent = 0;
	int pixels_checked = 0;
	int row_ends_checked = 0;
	int capped_samples = 0;
	int negative_samples = 0;
	int src_stall_cycles = 0;
	int quiet_cycles = 0;

	aces_fitted_tone_map_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.last_in_row (last_in_row),
		.dst_valid   (dst_valid),
		.dst_stall   (dst_stall),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.row_end     (row_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Rational curve (x*(x+a)-b)/(x*(c*x+d)+e) on a Q16 value, with the
	// quotient rounded to nearest and floored on negative dividends.
	function automatic longint rational_curve(longint m);
		longint t;
		longint num;
		longint den;
		longint dividend;
		longint quo;
		t = (CRV_C * m + 32768) >>> 16;
		num = m * (m + CRV_A) - CRV_B * 65536;
		den = m * (t + CRV_D) + CRV_E * 65536;
		// The quadratic has no real roots, so this floor is a guard only.
		if (den < 1)
			den = 1;
		dividend = num * 65536 + den / 2;
		quo = dividend / den;
		if (dividend % den != 0 && dividend < 0)
			quo = quo - 1;
		return quo;
	endfunction

	// Output matrix sum back to the sample format, capped at 1.0 on top
	// (or at the field maximum when 1.0 does not fit) and saturated below.
	function automatic pix_t clamp_sample(longint acc);
		longint y;
		longint top;
		y = (acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
		top = (FB >= 15) ? 32767 : (longint'(1) <<< FB);
		if (y > top)
			y = top;
		if (y < -32768)
			y = -32768;
		return pix_t'(y);
	endfunction

	// Full tone map of one pixel: input matrix, curve per channel, output matrix.
	function automatic rgb_pixel_t tone_map_pixel(pix_t r, pix_t g, pix_t b, logic last);
		longint lr;
		longint lg;
		longint lb;
		longint half;
		longint cr;
		longint cg;
		longint cb;
		rgb_pixel_t px;
		lr = r;
		lg = g;
		lb = b;
		half = longint'(1) <<< (FB - 1);
		cr = rational_curve((IN_RR * lr + IN_RG * lg + IN_RB * lb + half) >>> FB);
		cg = rational_curve((IN_GR * lr + IN_GG * lg + IN_GB * lb + half) >>> FB);
		cb = rational_curve((IN_BR * lr + IN_BG * lg + IN_BB * lb + half) >>> FB);
		px.red = clamp_sample(OUT_RR * cr + OUT_RG * cg + OUT_RB * cb);
		px.green = clamp_sample(OUT_GR * cr + OUT_GG * cg + OUT_GB * cb);
		px.blue = clamp_sample(OUT_BR * cr + OUT_BG * cg + OUT_BB * cb);
		px.last = last;
		return px;
	endfunction

	function automatic pix_t random_sample(sample_span_e span);
		case (span)
			SPAN_FULL: return pix_t'($urandom);
			SPAN_HDR:  return pix_t'($urandom_range(32767));
			SPAN_KNEE: return pix_t'(int'($urandom_range(1024)) - 512);
			default:   return pix_t'($urandom_range(2 * 4096));
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Offers one pixel beat and returns at the edge where it is taken.
	// Called at a rising edge; the idle cycles in front of the beat keep
	// src_valid low, and valid stays up with a fixed payload while stalled.
	task automatic send_pixel(pix_t r, pix_t g, pix_t b, logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		last_in_row <= last;
		do
			@(posedge clk);
		while (src_stall);
		pending_pixels.push_back(tone_map_pixel(r, g, b, last));
		pixels_sent++;
	endtask

	task automatic send_random_pixel(logic last);
		int pick;
		pix_t gray;
		pick = $urandom_range(9);
		if (pick <= 3)
			send_pixel(random_sample(SPAN_FULL), random_sample(SPAN_FULL),
				random_sample(SPAN_FULL), last);
		else if (pick <= 5)
			send_pixel(random_sample(SPAN_HDR), random_sample(SPAN_HDR),
				random_sample(SPAN_HDR), last);
		else if (pick == 6)
			send_pixel(random_sample(SPAN_SDR), random_sample(SPAN_SDR),
				random_sample(SPAN_SDR), last);
		else if (pick <= 8)
			send_pixel(random_sample(SPAN_KNEE), random_sample(SPAN_KNEE),
				random_sample(SPAN_KNEE), last);
		else begin
			// Neutral gray: all three channels equal.
			gray = random_sample(SPAN_HDR);
			send_pixel(gray, gray, gray, last);
		end
	endtask

	// Sends rows of random length, marking the last pixel of each row.
	task automatic send_rows(int count);
		int row_left;
		row_left = 0;
		repeat (count) begin
			if (row_left == 0)
				row_left = $urandom_range(48, 1);
			send_random_pixel(row_left == 1);
			row_left--;
		end
	endtask

	// Field extremes, black, exactly 1.0, tiny values on both sides of zero
	// and single-channel pixels. Bright pixels drive the output into the 1.0
	// cap, and mixed-sign pixels push the output matrix toward negative sums.
	task automatic test_extreme_pixels;
		send_pixel(0, 0, 0, 1'b0);
		send_pixel(PIX_MAX, PIX_MAX, PIX_MAX, 1'b1);
		send_pixel(PIX_MIN, PIX_MIN, PIX_MIN, 1'b0);
		send_pixel(PIX_ONE, PIX_ONE, PIX_ONE, 1'b1);
		send_pixel(1, 1, 1, 1'b0);
		send_pixel(-1, -1, -1, 1'b1);
		send_pixel(PIX_MAX, 0, 0, 1'b0);
		send_pixel(0, PIX_MAX, 0, 1'b0);
		send_pixel(0, 0, PIX_MAX, 1'b1);
		send_pixel(PIX_MIN, 0, 0, 1'b0);
		send_pixel(0, PIX_MIN, 0, 1'b0);
		send_pixel(0, 0, PIX_MIN, 1'b1);
		send_pixel(PIX_MAX, PIX_MIN, PIX_MAX, 1'b0);
		send_pixel(PIX_MIN, PIX_MAX, PIX_MIN, 1'b1);
		send_pixel(0, PIX_MAX, PIX_MIN, 1'b0);
		send_pixel(-50, 0, 0, 1'b0);
		send_pixel(0, PIX_ONE, 0, 1'b1);
		send_pixel(16'sh5555, -16'sh5556, 16'sh2aaa, 1'b0);
	endtask

	// Short rows, so that the row mark toggles often.
	task automatic test_row_marks;
		send_rows(60);
	endtask

	// The bulk of the run: random pixels in random rows with random idling.
	task automatic test_random_pixels;
		send_rows(1200);
	endtask

	// A long stretch with no idling on either side, one beat per cycle.
	task automatic test_back_to_back;
		src_idle_pct = 0;
		dst_idle_pct = 0;
		send_rows(250);
		src_idle_pct = 38;
		dst_idle_pct = 38;
	endtask

	// The source never idles while the sink stalls, so the pipeline fills up
	// and the block has to push back on the source.
	task automatic test_full_pipeline;
		src_idle_pct = 0;
		send_rows(200);
		src_idle_pct = 38;
	endtask

	// Result side: compares every accepted beat with the oldest pending pixel
	// and then picks the stall for the next cycle.
	always @(posedge clk) begin : result_check
		rgb_pixel_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			if (pending_pixels.size() == 0)
				report_mismatch("result beat arrived with no pixel outstanding");
			else begin
				want = pending_pixels.pop_front();
				if (red_out !== want.red)
					report_mismatch($sformatf("pixel %0d red_out is %0d, want %0d",
						pixels_checked, red_out, want.red));
				if (green_out !== want.green)
					report_mismatch($sformatf("pixel %0d green_out is %0d, want %0d",
						pixels_checked, green_out, want.green));
				if (blue_out !== want.blue)
					report_mismatch($sformatf("pixel %0d blue_out is %0d, want %0d",
						pixels_checked, blue_out, want.blue));
				if (row_end !== want.last)
					report_mismatch($sformatf("pixel %0d row_end is %b, want %b",
						pixels_checked, row_end, want.last));
				if (want.last)
					row_ends_checked++;
				capped_samples += (want.red == PIX_ONE) + (want.green == PIX_ONE)
					+ (want.blue == PIX_ONE);
				negative_samples += (want.red < 0) + (want.green < 0) + (want.blue < 0);
				pixels_checked++;
			end
		end
		dst_stall <= ($urandom_range(99) < dst_idle_pct);
	end

	// Watchdog: any cycle with a beat on either channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && src_stall)
				src_stall_cycles++;
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d pixels outstanding",
					STALL_LIMIT, pending_pixels.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		// Reset is held from the start and released on a clock edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_pixels;
		test_row_marks;
		test_random_pixels;
		test_back_to_back;
		test_full_pipeline;

		src_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		// Anything the block still emits after this point is a stray beat.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Tone-mapped %0d of %0d pixels, %0d of them row ends; source held off %0d cycles.",
			pixels_checked, pixels_sent, row_ends_checked, src_stall_cycles);
		$display("%0d output samples landed on the 1.0 cap, %0d came out below zero; %0d mismatches.",
			capped_samples, negative_samples, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: aces_fitted_tone_map_top.f
hw/rtl/afm_pkg.sv
hw/rtl/afm_lane.sv
hw/rtl/afm_merge.sv
hw/rtl/aces_fitted_tone_map_top.sv
test/aces_fitted_tone_map_top_test.sv
